FILE: hw/rtl/rnc_pkg.sv
`timescale 1ns / 1ps

package rnc_pkg;

   localparam int N_W   = 11;
   localparam int WAY_W = 30;
   localparam logic [WAY_W-1:0] WAY_MOD = 30'd1000000003;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_SEND
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctl_type;

   // sum of two residues, one conditional subtraction
   function automatic logic [WAY_W-1:0] mod_add(input logic [WAY_W-1:0] a,
                                                input logic [WAY_W-1:0] b);
      logic [WAY_W:0] s;
      logic [WAY_W:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, WAY_MOD};
      if (s >= {1'b0, WAY_MOD}) begin
         return d[WAY_W-1:0];
      end
      return s[WAY_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/rnc_cell.sv
`timescale 1ns / 1ps

// cell k holds column (m - k) of the two latest line rows
module rnc_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  rnc_pkg::cell_ctl_type         ctl,
   input  logic [rnc_pkg::N_W-1:0]       pick_count,
   input  logic [rnc_pkg::WAY_W-1:0]     older_next,
   output logic [rnc_pkg::WAY_W-1:0]     newer_q,
   output logic [rnc_pkg::WAY_W-1:0]     older_q
);

   logic                          hold_ff, hold_in;
   logic [rnc_pkg::WAY_W-1:0]     newer_ff, newer_in;
   logic [rnc_pkg::WAY_W-1:0]     older_ff, older_in;
   logic                          is_base;

   // the cell at index m is column zero, a constant one in both rows
   assign is_base = (32'(pick_count) == 32'(INDEX));

   always_comb begin
      hold_in  = hold_ff;
      newer_in = newer_ff;
      older_in = older_ff;
      if (ctl.load) begin
         hold_in  = (32'(INDEX) >= 32'(pick_count));
         newer_in = is_base ? rnc_pkg::WAY_W'(1) : '0;
         older_in = is_base ? rnc_pkg::WAY_W'(1) : '0;
      end else if (ctl.step && !hold_ff) begin
         newer_in = rnc_pkg::mod_add(older_next, newer_ff);
         older_in = newer_ff;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      newer_ff <= newer_in;
      older_ff <= older_in;
   end

   assign newer_q = newer_ff;
   assign older_q = older_ff;

endmodule

FILE: hw/rtl/rnc_seq.sv
`timescale 1ns / 1ps

module rnc_seq #(
   parameter int MAX_RING = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rnc_pkg::N_W-1:0]       ring_size,
   input  logic [rnc_pkg::N_W-1:0]       pick_count,
   input  logic [rnc_pkg::WAY_W-1:0]     col_m,
   input  logic [rnc_pkg::WAY_W-1:0]     col_m_less,
   output rnc_pkg::cell_ctl_type         ctl,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rnc_pkg::WAY_W-1:0]     way_count
);

   rnc_pkg::seq_state_type        state_ff, state_in;
   logic [rnc_pkg::N_W-1:0]       n_ff, n_in;
   logic [rnc_pkg::N_W-1:0]       cnt_ff, cnt_in;
   logic [rnc_pkg::WAY_W-1:0]     saved_ff, saved_in;
   logic [rnc_pkg::WAY_W-1:0]     way_ff, way_in;
   logic                          bad_req;

   assign bad_req = (ring_size < rnc_pkg::N_W'(4)) || (32'(ring_size) > 32'(MAX_RING))
                    || (pick_count == '0) || (pick_count > (ring_size >> 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rnc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff     <= n_in;
      cnt_ff   <= cnt_in;
      saved_ff <= saved_in;
      way_ff   <= way_in;
   end

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      cnt_in     = cnt_ff;
      saved_in   = saved_ff;
      way_in     = way_ff;
      ctl        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         rnc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               n_in     = ring_size;
               cnt_in   = '0;
               saved_in = '0;
               if (bad_req) begin
                  way_in   = '0;
                  state_in = rnc_pkg::S_SEND;
               end else begin
                  state_in = rnc_pkg::S_RUN;
               end
            end
         end
         rnc_pkg::S_RUN: begin
            // after cnt steps the chain holds line row cnt
            if (cnt_ff == n_ff - rnc_pkg::N_W'(1)) begin
               way_in   = rnc_pkg::mod_add(saved_ff, col_m);
               state_in = rnc_pkg::S_SEND;
            end else begin
               ctl.step = 1'b1;
               cnt_in   = cnt_ff + rnc_pkg::N_W'(1);
               if (cnt_ff == n_ff - rnc_pkg::N_W'(3)) begin
                  saved_in = col_m_less;
               end
            end
         end
         rnc_pkg::S_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = rnc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rnc_pkg::S_IDLE;
         end
      endcase
   end

   assign way_count = way_ff;

endmodule

FILE: hw/rtl/ring_nonadjacent_choice_count.sv
`timescale 1ns / 1ps
// a valid request steps through the line rows in S_RUN before its result is sent; a
// request that is out of range goes straight to S_SEND (the answer is then zero)
// throughput: a new request is taken only once the last result is delivered; one line
// row per cycle through a chain of MAX_RING/2 + 1 cells, one cell per pick column
// reset: synchronous active high, returns the sequencer to idle; cells load per request
module ring_nonadjacent_choice_count #(
   parameter int MAX_RING = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // ring_size [10:0], pick_count [21:11], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // way_count [29:0], zero pad
);

   localparam int NUM_CELLS = MAX_RING / 2 + 1;

   rnc_pkg::cell_ctl_type         ctl;
   logic [rnc_pkg::N_W-1:0]       ring_size;
   logic [rnc_pkg::N_W-1:0]       pick_count;
   logic [rnc_pkg::WAY_W-1:0]     way_count;
   logic [rnc_pkg::WAY_W-1:0]     newer_w [NUM_CELLS];
   logic [rnc_pkg::WAY_W-1:0]     older_w [NUM_CELLS+1];

   assign ring_size  = req_tdata[10:0];
   assign pick_count = req_tdata[21:11];

   assign older_w[NUM_CELLS] = '0;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      rnc_cell #(
         .INDEX(k)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pick_count (pick_count),
         .older_next (older_w[k+1]),
         .newer_q    (newer_w[k]),
         .older_q    (older_w[k])
      );
   end

   rnc_seq #(
      .MAX_RING(MAX_RING)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ring_size  (ring_size),
      .pick_count (pick_count),
      .col_m      (newer_w[0]),
      .col_m_less (newer_w[1]),
      .ctl        (ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .way_count  (way_count)
   );

   assign rsp_tdata = {2'b00, way_count};

endmodule

FILE: hw/rtl/rnc_checker.sv
`timescale 1ns / 1ps

module rnc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   // the count is a reduced residue
   a_residue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:30] == 2'b00) && (rsp_tdata[29:0] < 30'd1000000003))
      else $error("result not reduced");

   // a request with no picks answers zero at once
   a_no_picks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[21:11] == 11'd0)
      |=> rsp_tvalid && (rsp_tdata == 32'd0))
      else $error("empty pick request not answered with zero");

   // a delivered result is not repeated
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result repeated");

endmodule

bind ring_nonadjacent_choice_count rnc_checker u_rnc_checker (.*);
